### sv/bm3_pkg.sv
package bm3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int SIZE_W = 11;
    localparam int MODE_W = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd480;

    localparam logic [MODE_W-1:0] MODE_DILATE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERODE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAJORITY = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    // window geometry and majority threshold
    localparam int WIN_COLS  = 3;
    localparam int ONES_W    = 4;
    localparam int MAJ_COUNT = 5;

    // line store word: upper row bit, middle row bit
    localparam int LINE_BITS = 2;

    typedef struct packed {
        logic       any;
        logic       all;
        logic [1:0] ones;
    } t_col_sum;

    typedef struct packed {
        logic emit;
        logic last;
        logic inner;
    } t_pos_flags;

    function automatic t_col_sum f_col_sum(input logic [2:0] col);
        t_col_sum s;
        s.any  = |col;
        s.all  = &col;
        s.ones = 2'(col[0]) + 2'(col[1]) + 2'(col[2]);
        return s;
    endfunction

endpackage

### sv/bm3_ram.sv
module bm3_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bm3_cell.sv
// one window column: holds the summary of a column and hands it on
module bm3_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  bm3_pkg::t_col_sum i_sum,
    output bm3_pkg::t_col_sum o_sum
);

    bm3_pkg::t_col_sum r_sum;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sum <= i_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

### sv/bm3_pos.sv
// raster position of the pixel being taken, with wrap on size changes
module bm3_pos #(
    parameter int MAX_WIDTH  = bm3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bm3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_frame_start,
    input  logic [bm3_pkg::SIZE_W-1:0]    i_width,
    input  logic [bm3_pkg::SIZE_W-1:0]    i_height,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_col,
    output bm3_pkg::t_pos_flags           o_flags
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWL = $clog2(MAX_WIDTH + 1);
    localparam int SHL = $clog2(MAX_HEIGHT + 1);
    localparam int SW  = (SWL > bm3_pkg::SIZE_W) ? SWL : bm3_pkg::SIZE_W;
    localparam int SH  = (SHL > bm3_pkg::SIZE_W) ? SHL : bm3_pkg::SIZE_W;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [SW-1:0] w_ext, w, cn;
    logic [SH-1:0] h_ext, h, r1, rn;
    logic [CW-1:0] c0, c;
    logic [RW-1:0] r0, r;

    always_comb begin
        // sizes saturated to the supported range
        w_ext = SW'(i_width);
        h_ext = SH'(i_height);
        if (w_ext < SW'(3)) begin
            w = SW'(3);
        end else if (w_ext > SW'(MAX_WIDTH)) begin
            w = SW'(MAX_WIDTH);
        end else begin
            w = w_ext;
        end
        if (h_ext < SH'(3)) begin
            h = SH'(3);
        end else if (h_ext > SH'(MAX_HEIGHT)) begin
            h = SH'(MAX_HEIGHT);
        end else begin
            h = h_ext;
        end

        c0 = i_frame_start ? '0 : r_col;
        r0 = i_frame_start ? '0 : r_row;
        if (SW'(c0) >= w) begin
            c  = '0;
            r1 = SH'(r0) + SH'(1);
        end else begin
            c  = c0;
            r1 = SH'(r0);
        end
        r = (r1 >= h) ? '0 : r1[RW-1:0];

        cn = SW'(c) + SW'(1);
        rn = SH'(r) + SH'(1);
        if (cn >= w) begin
            n_col = '0;
            n_row = (rn >= h) ? '0 : rn[RW-1:0];
        end else begin
            n_col = cn[CW-1:0];
            n_row = r;
        end

        o_flags.emit  = (r >= RW'(2)) || ((r == RW'(1)) && (c != '0));
        o_flags.last  = (SH'(r) == h - SH'(1)) && (SW'(c) == w - SW'(1));
        o_flags.inner = (c >= CW'(2)) && (r >= RW'(2));
    end

    assign o_col = c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

### sv/binary_3x3_morph_filter.sv
// a pixel is registered in stage b, then its result in the output register
// results trail the input stream by frame width + 1 pixels (two stored rows)
// throughput: one pixel per cycle unless stalled (single line store ram port pair)
// reset: synchronous, active low; size registers go to 640 x 480, mode to dilation
// after reset a clearing pass zeroes all MAX_WIDTH words of the line store ram,
// during which input transfers are stalled (configuration writes still taken)
module binary_3x3_morph_filter #(
    parameter int MAX_WIDTH  = bm3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bm3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // pixel input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_pixel_white,
    input  logic                         i_frame_start,
    // result output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_result_white,
    output logic                         o_frame_last,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bm3_pkg::ADDR_W-1:0]   paddr,
    input  logic [bm3_pkg::DATA_W-1:0]   pwdata,
    output logic [bm3_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CELLS = bm3_pkg::WIN_COLS - 1;

    // ---------------- configuration registers ----------------
    logic [bm3_pkg::SIZE_W-1:0] r_frame_width;
    logic [bm3_pkg::SIZE_W-1:0] r_frame_height;
    logic [bm3_pkg::MODE_W-1:0] r_filter_mode;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bm3_pkg::WIDTH_RST;
            r_frame_height <= bm3_pkg::HEIGHT_RST;
            r_filter_mode  <= bm3_pkg::MODE_DILATE;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                bm3_pkg::REG_WIDTH:  r_frame_width  <= pwdata[bm3_pkg::SIZE_W-1:0];
                bm3_pkg::REG_HEIGHT: r_frame_height <= pwdata[bm3_pkg::SIZE_W-1:0];
                bm3_pkg::REG_MODE:   r_filter_mode  <= pwdata[bm3_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bm3_pkg::REG_WIDTH:  prdata = bm3_pkg::DATA_W'(r_frame_width);
            bm3_pkg::REG_HEIGHT: prdata = bm3_pkg::DATA_W'(r_frame_height);
            bm3_pkg::REG_MODE:   prdata = bm3_pkg::DATA_W'(r_filter_mode);
            default:             prdata = '0;
        endcase
    end

    // ---------------- line store clearing pass ----------------
    logic          r_clearing;
    logic [CW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + CW'(1);
            if (r_clr_cnt == CW'(MAX_WIDTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // ---------------- handshake and stage control ----------------
    // stage b: pixel with its line store bits; stage c: output register
    logic in_accept;
    logic b_adv;
    logic r_b_valid;
    logic r_c_valid;

    assign b_adv      = r_b_valid && (!r_c_valid || !i_out_stall);
    assign o_in_stall = r_clearing || (r_b_valid && !b_adv);
    assign in_accept  = i_in_valid && !o_in_stall;

    // ---------------- raster position ----------------
    logic [CW-1:0]       pos_col;
    bm3_pkg::t_pos_flags pos_flags;

    bm3_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_frame_start (i_frame_start),
        .i_width       (r_frame_width),
        .i_height      (r_frame_height),
        .o_col         (pos_col),
        .o_flags       (pos_flags)
    );

    // ---------------- line store ram ----------------
    // bit 1 holds the row two above, bit 0 the row just above
    logic                          ram_we;
    logic [CW-1:0]                 ram_waddr;
    logic [bm3_pkg::LINE_BITS-1:0] ram_wdata;
    logic [bm3_pkg::LINE_BITS-1:0] ram_rdata;

    // stage b registers
    logic                r_b_pix;
    logic [CW-1:0]       r_b_col;
    bm3_pkg::t_pos_flags r_b_flags;
    logic                r_b_fwd;
    logic                r_b_fwd_up;
    logic                r_b_fwd_mid;
    logic                up_bit;
    logic                mid_bit;

    // the ram read happens in the same edge as the write of the item ahead;
    // when both hit the same column the written bits are forwarded
    assign up_bit  = r_b_fwd ? r_b_fwd_up  : ram_rdata[1];
    assign mid_bit = r_b_fwd ? r_b_fwd_mid : ram_rdata[0];

    assign ram_we    = r_clearing || b_adv;
    assign ram_waddr = r_clearing ? r_clr_cnt : r_b_col;
    assign ram_wdata = r_clearing ? '0 : {mid_bit, r_b_pix};

    bm3_ram #(
        .WIDTH (bm3_pkg::LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (pos_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (in_accept) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_b_pix     <= i_pixel_white;
            r_b_col     <= pos_col;
            r_b_flags   <= pos_flags;
            r_b_fwd     <= b_adv && (pos_col == r_b_col);
            r_b_fwd_up  <= mid_bit;
            r_b_fwd_mid <= r_b_pix;
        end
    end

    // ---------------- window: chain of column cells ----------------
    // win_sum[0] is the column of the current pixel, the cells hold the two before
    bm3_pkg::t_col_sum win_sum [bm3_pkg::WIN_COLS];

    assign win_sum[0] = bm3_pkg::f_col_sum({up_bit, mid_bit, r_b_pix});

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        bm3_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (b_adv),
            .i_sum   (win_sum[k]),
            .o_sum   (win_sum[k+1])
        );
    end

    // ---------------- filter decision ----------------
    logic                      win_any;
    logic                      win_all;
    logic [bm3_pkg::ONES_W-1:0] win_ones;
    logic                      filt_res;

    always_comb begin
        win_any  = 1'b0;
        win_all  = 1'b1;
        win_ones = '0;
        for (int k = 0; k < bm3_pkg::WIN_COLS; k++) begin
            win_any  = win_any | win_sum[k].any;
            win_all  = win_all & win_sum[k].all;
            win_ones = win_ones + bm3_pkg::ONES_W'(win_sum[k].ones);
        end
        unique case (r_filter_mode)
            bm3_pkg::MODE_DILATE:   filt_res = win_any;
            bm3_pkg::MODE_ERODE:    filt_res = win_all;
            bm3_pkg::MODE_MAJORITY: filt_res = win_ones >= bm3_pkg::ONES_W'(bm3_pkg::MAJ_COUNT);
            default:                filt_res = 1'b0;
        endcase
    end

    // ---------------- output register ----------------
    logic r_c_result;
    logic r_c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (b_adv) begin
            // pixels of the first row and the first pixel of the second make no result
            r_c_valid <= r_b_flags.emit;
        end else if (!i_out_stall) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            // border positions always come out black
            r_c_result <= r_b_flags.inner && filt_res;
            r_c_last   <= r_b_flags.last;
        end
    end

    assign o_out_valid    = r_c_valid;
    assign o_result_white = r_c_result;
    assign o_frame_last   = r_c_last;

`ifndef SYNTHESIS
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !in_accept)
        else $error("pixel transfer during line store clearing");

    a_stage_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_adv) |-> !in_accept)
        else $error("stage b overwritten while it holds a pixel");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_result_white) && $stable(o_frame_last)))
        else $error("stalled result changed");

    a_result_from_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(b_adv))
        else $error("result appeared without a stage b transfer");
`endif

endmodule
